FILE: hw/rtl/sid_pkg.sv
package sid_pkg;

	// default operand width
	localparam int DEF_WIDTH = 32;

	// control that travels with each item down the cell row
	typedef struct packed {
		logic valid;
		logic num_pos;
		logic negate;
		logic div_zero;
	} sid_ctl_t;

endpackage

FILE: hw/rtl/signed_integer_divider.sv
// channel   dir  handshake          tdata fields (lowest bit first)
// s_        in   s_tvalid/s_tready  dividend[WIDTH], divisor[WIDTH], zero fill to bytes
// m_        out  m_tvalid/m_tready  quotient[WIDTH], zero fill to bytes
//
// a transaction passes a setup stage, a row of WIDTH divide cells (one quotient
// bit each, a compare and subtract per cell) and a sign fix stage, one transaction
// per cycle while no result is held on m_.
// arst_n clears the valid bit of every stage; data registers are not reset.
// the whole row advances together: a result held on m_ stalls every stage and
// drops s_tready.
module signed_integer_divider #(
	parameter int  WIDTH = sid_pkg::DEF_WIDTH,
	localparam int IN_W  = ((2 * WIDTH + 7) / 8) * 8,
	localparam int OUT_W = ((WIDTH + 7) / 8) * 8
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             s_tvalid,
	output logic             s_tready,
	input  logic [IN_W-1:0]  s_tdata,   // dividend, divisor
	output logic             m_tvalid,
	input  logic             m_tready,
	output logic [OUT_W-1:0] m_tdata    // quotient
);

	sid_pkg::sid_ctl_t ctl_c [0:WIDTH];
	logic [WIDTH-1:0]  rem_c [0:WIDTH];
	logic [WIDTH-1:0]  nq_c  [0:WIDTH];
	logic [WIDTH-1:0]  den_c [0:WIDTH];
	logic              adv;
	logic [WIDTH-1:0]  quotient;

	// every stage moves when the output register is free or being drained
	assign adv      = !m_tvalid || m_tready;
	assign s_tready = adv;

	// sign and magnitude setup
	sid_setup #(.WIDTH(WIDTH)) u_setup (
		.clk      (clk),
		.arst_n   (arst_n),
		.adv      (adv),
		.in_valid (s_tvalid),
		.dividend (s_tdata[WIDTH-1:0]),
		.divisor  (s_tdata[2*WIDTH-1:WIDTH]),
		.ctl      (ctl_c[0]),
		.num_mag  (nq_c[0]),
		.den_mag  (den_c[0])
	);

	assign rem_c[0] = '0;

	// row of divide cells, most significant quotient bit first
	for (genvar i = 0; i < WIDTH; i++) begin : g_cell
		sid_cell #(.WIDTH(WIDTH)) u_cell (
			.clk     (clk),
			.arst_n  (arst_n),
			.adv     (adv),
			.ctl_in  (ctl_c[i]),
			.rem_in  (rem_c[i]),
			.nq_in   (nq_c[i]),
			.den_in  (den_c[i]),
			.ctl_out (ctl_c[i+1]),
			.rem_out (rem_c[i+1]),
			.nq_out  (nq_c[i+1]),
			.den_out (den_c[i+1])
		);
	end

	// sign fix and output register
	sid_finish #(.WIDTH(WIDTH)) u_finish (
		.clk       (clk),
		.arst_n    (arst_n),
		.adv       (adv),
		.ctl       (ctl_c[WIDTH]),
		.mag_q     (nq_c[WIDTH]),
		.out_valid (m_tvalid),
		.quotient  (quotient)
	);

	assign m_tdata = OUT_W'(quotient);

endmodule

FILE: hw/rtl/sid_setup.sv
module sid_setup #(
	parameter int WIDTH = sid_pkg::DEF_WIDTH
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              adv,
	input  logic              in_valid,
	input  logic [WIDTH-1:0]  dividend,
	input  logic [WIDTH-1:0]  divisor,
	output sid_pkg::sid_ctl_t ctl,
	output logic [WIDTH-1:0]  num_mag,
	output logic [WIDTH-1:0]  den_mag
);

	sid_pkg::sid_ctl_t ctl_s1;
	logic [WIDTH-1:0]  num_mag_s1;
	logic [WIDTH-1:0]  den_mag_s1;
	logic              num_pos;
	logic              den_pos;

	// strictly positive operands decide the sign of the result
	assign num_pos = (dividend != '0) && !dividend[WIDTH-1];
	assign den_pos = (divisor != '0) && !divisor[WIDTH-1];

	// sign flags, valid cleared on reset
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctl_s1 <= '0;
		end else if (adv) begin
			ctl_s1.valid    <= in_valid;
			ctl_s1.num_pos  <= num_pos;
			ctl_s1.negate   <= num_pos ^ den_pos;
			ctl_s1.div_zero <= (divisor == '0);
		end
	end

	// unsigned magnitudes, most negative value maps to 2^(WIDTH-1)
	always_ff @(posedge clk) begin
		if (adv) begin
			num_mag_s1 <= dividend[WIDTH-1] ? (~dividend + 1'b1) : dividend;
			den_mag_s1 <= divisor[WIDTH-1] ? (~divisor + 1'b1) : divisor;
		end
	end

	assign ctl     = ctl_s1;
	assign num_mag = num_mag_s1;
	assign den_mag = den_mag_s1;

endmodule

FILE: hw/rtl/sid_cell.sv
module sid_cell #(
	parameter int WIDTH = sid_pkg::DEF_WIDTH
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              adv,
	input  sid_pkg::sid_ctl_t ctl_in,
	input  logic [WIDTH-1:0]  rem_in,
	input  logic [WIDTH-1:0]  nq_in,
	input  logic [WIDTH-1:0]  den_in,
	output sid_pkg::sid_ctl_t ctl_out,
	output logic [WIDTH-1:0]  rem_out,
	output logic [WIDTH-1:0]  nq_out,
	output logic [WIDTH-1:0]  den_out
);

	sid_pkg::sid_ctl_t ctl_q;
	logic [WIDTH-1:0]  rem_q;
	logic [WIDTH-1:0]  nq_q;
	logic [WIDTH-1:0]  den_q;
	logic [WIDTH:0]    trial;
	logic [WIDTH:0]    diff;
	logic              fits;

	// one restoring step: bring down the next dividend bit and try a subtract
	assign trial = {rem_in, nq_in[WIDTH-1]};
	assign diff  = trial - {1'b0, den_in};
	assign fits  = (trial >= {1'b0, den_in});

	// control handed to the next cell
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctl_q <= '0;
		end else if (adv) begin
			ctl_q <= ctl_in;
		end
	end

	// partial remainder, dividend bits shifting out and quotient bits shifting in
	always_ff @(posedge clk) begin
		if (adv) begin
			rem_q <= fits ? diff[WIDTH-1:0] : trial[WIDTH-1:0];
			nq_q  <= {nq_in[WIDTH-2:0], fits};
			den_q <= den_in;
		end
	end

	assign ctl_out = ctl_q;
	assign rem_out = rem_q;
	assign nq_out  = nq_q;
	assign den_out = den_q;

endmodule

FILE: hw/rtl/sid_finish.sv
module sid_finish #(
	parameter int WIDTH = sid_pkg::DEF_WIDTH
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              adv,
	input  sid_pkg::sid_ctl_t ctl,
	input  logic [WIDTH-1:0]  mag_q,
	output logic              out_valid,
	output logic [WIDTH-1:0]  quotient
);

	localparam logic [WIDTH-1:0] MAX_POS = {1'b0, {(WIDTH-1){1'b1}}};
	localparam logic [WIDTH-1:0] MIN_NEG = {1'b1, {(WIDTH-1){1'b0}}};

	logic             valid_q;
	logic [WIDTH-1:0] quotient_q;
	logic [WIDTH-1:0] result;

	// divide by zero, sign fix and overflow saturation
	always_comb begin
		if (ctl.div_zero) begin
			result = ctl.num_pos ? MAX_POS : MIN_NEG;
		end else if (ctl.negate) begin
			result = ~mag_q + 1'b1;
		end else if (mag_q[WIDTH-1]) begin
			result = MAX_POS;
		end else begin
			result = mag_q;
		end
	end

	// output valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (adv) begin
			valid_q <= ctl.valid;
		end
	end

	// output data
	always_ff @(posedge clk) begin
		if (adv) begin
			quotient_q <= result;
		end
	end

	assign out_valid = valid_q;
	assign quotient  = quotient_q;

endmodule
